### hw/rtl/rra_pkg.sv
// ----------------------------------------------------------------------------
// rra_pkg
// Shared types and constants of the region allocator.
// ----------------------------------------------------------------------------
package rra_pkg;

    localparam int PAGE_SHIFT         = 20;
    localparam int PAGE_BYTES         = 1 << PAGE_SHIFT;
    localparam int DEFAULT_PAGE_SLOTS = 16;

    localparam int SIZE_W   = 24;
    localparam int ADDR_W   = 25;
    localparam int STATUS_W = 3;
    localparam int LIVE_W   = 5;
    localparam int FILL_W   = PAGE_SHIFT + 1;
    localparam int REFS_W   = PAGE_SHIFT - 2;
    localparam int PAGE_W   = ADDR_W - PAGE_SHIFT;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LARGE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOSLOT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd4;

    typedef struct packed {
        logic              op;
        logic [SIZE_W-1:0] size_bytes;
        logic [ADDR_W-1:0] block_address;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   granted_address;
        logic [STATUS_W-1:0] status;
        logic [LIVE_W-1:0]   live_pages;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

endpackage

### hw/rtl/rra_ctrl.sv
// ----------------------------------------------------------------------------
// rra_ctrl
// Sequencer: accept, scan the slot tables, evaluate and commit one request.
// ----------------------------------------------------------------------------
module rra_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output rra_pkg::ctrl_cmd_t cmd
);
    import rra_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        EVAL
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;
    logic   m_valid_reg, m_valid_next;
    logic   load, commit;

    assign load   = s_valid && s_ready_reg;
    assign commit = (state_reg == EVAL) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        s_ready_next = s_ready_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            IDLE: begin
                if (load) begin
                    state_next   = SCAN;
                    s_ready_next = 1'b0;
                end
            end
            SCAN: begin
                state_next = EVAL;
            end
            EVAL: begin
                if (commit) begin
                    state_next   = IDLE;
                    s_ready_next = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready    = s_ready_reg;
    assign m_valid    = m_valid_reg;
    assign cmd.load   = load;
    assign cmd.scan   = (state_reg == SCAN);
    assign cmd.commit = commit;

endmodule

### hw/rtl/rra_datapath.sv
// ----------------------------------------------------------------------------
// rra_datapath
// Slot tables, page stack, request decode and result register.
// ----------------------------------------------------------------------------
module rra_datapath #(
    parameter int PAGE_SLOTS = rra_pkg::DEFAULT_PAGE_SLOTS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  rra_pkg::ctrl_cmd_t cmd,
    input  rra_pkg::in_item_t  s_data,
    output rra_pkg::out_item_t m_data
);
    import rra_pkg::*;

    localparam int SLOT_W = $clog2(PAGE_SLOTS);
    localparam int CNT_W  = $clog2(PAGE_SLOTS + 1);
    localparam int WORD_W = FILL_W + REFS_W;
    localparam int SUM_W  = SIZE_W + 2;

    // request decode
    in_item_t          req_reg;
    logic [SIZE_W:0]   rounded_reg, rounded_comb;
    logic              large_reg;
    logic              page_ok_reg, page_ok_comb;
    logic [SLOT_W-1:0] fslot_reg;
    logic [PAGE_W-1:0] page_comb;

    // slot state
    logic [PAGE_SLOTS-1:0] live_reg, live_next;
    logic [PAGE_SLOTS-1:0] entry_valid_reg;
    logic [SLOT_W-1:0]     stack_reg [PAGE_SLOTS];
    logic [SLOT_W-1:0]     stack_next [PAGE_SLOTS];
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [SLOT_W-1:0]     top_reg, top_next;

    // fill / reference memory
    logic [WORD_W-1:0] slot_mem [PAGE_SLOTS];
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_valid_reg;
    logic [SLOT_W-1:0] raddr;
    logic              mem_we;
    logic [SLOT_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [FILL_W-1:0] rd_fill;
    logic [REFS_W-1:0] rd_refs;

    // scan results
    logic              free_found_reg, free_found_comb;
    logic [SLOT_W-1:0] free_slot_reg, free_slot_comb;
    logic              match_found_reg, match_found_comb;
    logic [SLOT_W-1:0] match_idx_reg, match_idx_comb;

    out_item_t         out_reg, out_next;
    logic [SLOT_W-1:0] grant_slot;
    logic [FILL_W-1:0] grant_fill;
    logic              grant;
    logic [31:0]       grant_sum;
    logic [SUM_W-1:0]  fill_sum;
    logic [REFS_W-1:0] refs_dec;
    logic [SLOT_W-1:0] below_top;

    assign rounded_comb = (s_data.size_bytes == '0) ? (SIZE_W+1)'(8) :
        (((SIZE_W+1)'(s_data.size_bytes) + (SIZE_W+1)'(7)) & ~(SIZE_W+1)'(7));
    assign page_comb    = s_data.block_address[ADDR_W-1:PAGE_SHIFT];
    assign page_ok_comb = (page_comb != '0) && (int'(page_comb) <= PAGE_SLOTS);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg     <= s_data;
            rounded_reg <= rounded_comb;
            large_reg   <= (rounded_comb > (SIZE_W+1)'(PAGE_BYTES));
            page_ok_reg <= page_ok_comb;
            fslot_reg   <= SLOT_W'(page_comb - PAGE_W'(1));
        end
    end

    always_comb begin
        free_found_comb  = 1'b0;
        free_slot_comb   = '0;
        match_found_comb = 1'b0;
        match_idx_comb   = '0;
        for (int i = PAGE_SLOTS - 1; i >= 0; i--) begin
            if (!live_reg[i]) begin
                free_found_comb = 1'b1;
                free_slot_comb  = SLOT_W'(i);
            end
            if ((i < int'(count_reg)) && (stack_reg[i] == fslot_reg)) begin
                match_found_comb = 1'b1;
                match_idx_comb   = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan) begin
            free_found_reg  <= free_found_comb;
            free_slot_reg   <= free_slot_comb;
            match_found_reg <= match_found_comb;
            match_idx_reg   <= match_idx_comb;
        end
    end

    assign raddr = (req_reg.op == OP_ALLOC) ? top_reg : fslot_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[waddr] <= wdata;
        end
        rd_data_reg <= slot_mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
        end else begin
            if (mem_we) begin
                entry_valid_reg[waddr] <= 1'b1;
            end
            rd_valid_reg <= entry_valid_reg[raddr];
        end
    end

    assign rd_fill   = rd_valid_reg ? rd_data_reg[WORD_W-1:REFS_W] : '0;
    assign rd_refs   = rd_valid_reg ? rd_data_reg[REFS_W-1:0] : '0;
    assign fill_sum  = SUM_W'(rd_fill) + SUM_W'(rounded_reg);
    assign refs_dec  = rd_refs - REFS_W'(1);
    assign grant_sum = ((32'(grant_slot) + 32'd1) << PAGE_SHIFT) + 32'(grant_fill);

    always_comb begin
        below_top = '0;
        for (int i = 0; i < PAGE_SLOTS; i++) begin
            if (i + 2 == int'(count_reg)) begin
                below_top = stack_reg[i];
            end
        end
    end

    always_comb begin
        live_next  = live_reg;
        stack_next = stack_reg;
        count_next = count_reg;
        top_next   = top_reg;
        mem_we     = 1'b0;
        waddr      = raddr;
        wdata      = rd_data_reg;
        grant      = 1'b0;
        grant_slot = top_reg;
        grant_fill = rd_fill;
        out_next   = out_reg;
        out_next.status = ST_OK;
        if (req_reg.op == OP_ALLOC) begin
            if (large_reg) begin
                out_next.status = ST_LARGE;
            end else if (fill_sum <= SUM_W'(PAGE_BYTES)) begin
                grant  = 1'b1;
                mem_we = 1'b1;
                waddr  = top_reg;
                wdata  = {FILL_W'(fill_sum), rd_refs + REFS_W'(1)};
            end else if ((int'(count_reg) >= PAGE_SLOTS) || !free_found_reg) begin
                out_next.status = ST_NOSLOT;
            end else begin
                grant      = 1'b1;
                grant_slot = free_slot_reg;
                grant_fill = '0;
                mem_we     = 1'b1;
                waddr      = free_slot_reg;
                wdata      = {FILL_W'(rounded_reg), REFS_W'(1)};
                live_next[free_slot_reg] = 1'b1;
                for (int i = 0; i < PAGE_SLOTS; i++) begin
                    if (i == int'(count_reg)) begin
                        stack_next[i] = free_slot_reg;
                    end
                end
                count_next = count_reg + CNT_W'(1);
                top_next   = free_slot_reg;
            end
        end else begin
            if (req_reg.block_address == '0) begin
                out_next.status = ST_NULL;
            end else if (!page_ok_reg || !live_reg[fslot_reg] || (rd_refs == '0)) begin
                out_next.status = ST_INVALID;
            end else begin
                mem_we = 1'b1;
                waddr  = fslot_reg;
                wdata  = {rd_fill, refs_dec};
                if ((refs_dec == '0) && (int'(count_reg) > 1)) begin
                    live_next[fslot_reg] = 1'b0;
                    if (match_found_reg) begin
                        for (int j = 0; j < PAGE_SLOTS - 1; j++) begin
                            if ((j >= int'(match_idx_reg)) && (j + 1 < int'(count_reg))) begin
                                stack_next[j] = stack_reg[j + 1];
                            end
                        end
                        count_next = count_reg - CNT_W'(1);
                        if (int'(match_idx_reg) + 1 == int'(count_reg)) begin
                            top_next = below_top;
                        end
                    end
                end
            end
        end
        out_next.granted_address = grant ? grant_sum[ADDR_W-1:0] : '0;
        out_next.live_pages      = LIVE_W'(count_next);
        if (!cmd.commit) begin
            live_next  = live_reg;
            stack_next = stack_reg;
            count_next = count_reg;
            top_next   = top_reg;
            mem_we     = 1'b0;
            out_next   = out_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg  <= PAGE_SLOTS'(1);
            stack_reg <= '{default: '0};
            count_reg <= CNT_W'(1);
            top_reg   <= '0;
        end else begin
            live_reg  <= live_next;
            stack_reg <= stack_next;
            count_reg <= count_next;
            top_reg   <= top_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_data = out_reg;

endmodule

### hw/rtl/refcounted_region_allocator.sv
// ----------------------------------------------------------------------------
// refcounted_region_allocator
// Bump-pointer region allocator with per-page reference counts.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel (valid/ready): op selects allocate or free,
// size_bytes sizes an allocate, block_address names the block to free.
// Every request yields exactly one transfer on the m_ channel carrying the
// granted address, a status code and the number of live pages.
// A request is captured, then the live bits and the page stack are scanned,
// then the fill/reference table is read and the request commits. The result
// is registered and valid the cycle after commit; s_ready rises with it, so a
// new request is taken only once the one before it has committed.
// While m_ready is low the result holds and the block can still take the
// next request; that request waits in its commit step until the pending
// result is taken.
// After reset slot 0 is the only live page with no fill and no references;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module refcounted_region_allocator #(
    parameter int PAGE_SLOTS = rra_pkg::DEFAULT_PAGE_SLOTS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rra_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rra_pkg::out_item_t m_data
);
    import rra_pkg::*;

    ctrl_cmd_t cmd;

    rra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    rra_datapath #(
        .PAGE_SLOTS (PAGE_SLOTS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule

### verif/tb_refcounted_region_allocator.sv
// ----------------------------------------------------------------------------
// tb_refcounted_region_allocator
// Self-checking bench for the reference-counted region allocator.
// A directed run covers null, unknown and unreferenced frees, zero and
// oversized requests, an emptied last page, filling all slots and releasing
// a page from the middle of the stack. Random allocate/free traffic then runs
// under three idle mixes. A page-table model predicts every result.
// ----------------------------------------------------------------------------
module tb_refcounted_region_allocator;
    import rra_pkg::*;

    localparam int              SLOTS        = DEFAULT_PAGE_SLOTS;
    localparam int              RANDOM_ITEMS = 600;
    localparam int              CYCLE_LIMIT  = 200000;
    localparam int              DRAIN_CYCLES = 20;
    localparam longint unsigned PAGE         = PAGE_BYTES;

    class region_ledger;
        bit                slot_open[SLOTS];
        longint unsigned   slot_used[SLOTS];
        int unsigned       slot_blocks[SLOTS];
        int                open_order[SLOTS];
        int                open_count;
        logic [ADDR_W-1:0] held_blocks[$];
        out_item_t         expected_results[$];
        int                mismatches;

        function new();
            foreach (slot_open[i]) begin
                slot_open[i]   = 1'b0;
                slot_used[i]   = 0;
                slot_blocks[i] = 0;
                open_order[i]  = 0;
            end
            slot_open[0] = 1'b1;
            open_count   = 1;
            mismatches   = 0;
        endfunction

        function logic [ADDR_W-1:0] carve(int s, longint unsigned bytes);
            longint unsigned addr;
            addr = (s + 1) * PAGE + slot_used[s];
            slot_used[s] += bytes;
            slot_blocks[s]++;
            return addr[ADDR_W-1:0];
        endfunction

        function void note_request(in_item_t req);
            out_item_t       res;
            longint unsigned want;
            longint unsigned page;
            int              s;
            int              k;
            int              hit;

            res        = '0;
            res.status = ST_OK;
            if (req.op == OP_ALLOC) begin
                want = (req.size_bytes == 0) ? 64'd8 : 64'(req.size_bytes);
                want = (want + 7) & ~64'h7;
                if (want > PAGE) begin
                    res.status = ST_LARGE;
                end else if (slot_used[open_order[open_count-1]] + want <= PAGE) begin
                    res.granted_address = carve(open_order[open_count-1], want);
                end else begin
                    s = 0;
                    while (s < SLOTS && slot_open[s]) s++;
                    if (open_count >= SLOTS || s >= SLOTS) begin
                        res.status = ST_NOSLOT;
                    end else begin
                        slot_open[s]           = 1'b1;
                        slot_used[s]           = 0;
                        slot_blocks[s]         = 0;
                        open_order[open_count] = s;
                        open_count++;
                        res.granted_address = carve(s, want);
                    end
                end
                if (res.status == ST_OK) held_blocks = {held_blocks, res.granted_address};
            end else if (req.block_address == 0) begin
                res.status = ST_NULL;
            end else begin
                page = req.block_address / PAGE;
                if (page < 1 || page > SLOTS) begin
                    res.status = ST_INVALID;
                end else begin
                    s = int'(page) - 1;
                    if (!slot_open[s] || slot_blocks[s] == 0) begin
                        res.status = ST_INVALID;
                    end else begin
                        slot_blocks[s]--;
                        // retire one held block of this page, the exact one if known
                        hit = -1;
                        foreach (held_blocks[i]) begin
                            if (hit < 0 && held_blocks[i] / PAGE == page) hit = i;
                        end
                        foreach (held_blocks[i]) begin
                            if (held_blocks[i] == req.block_address) hit = i;
                        end
                        if (hit >= 0) held_blocks.delete(hit);
                        if (slot_blocks[s] == 0 && open_count > 1) begin
                            slot_open[s] = 1'b0;
                            k = 0;
                            while (open_order[k] != s) k++;
                            for (; k + 1 < open_count; k++) open_order[k] = open_order[k+1];
                            open_count--;
                        end
                    end
                end
            end
            res.live_pages = LIVE_W'(open_count);
            expected_results = {expected_results, res};
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;

            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: addr %h status %0d live %0d",
                             got.granted_address, got.status, got.live_pages);
                return;
            end
            want = expected_results.pop_front();
            if (got.granted_address !== want.granted_address || got.status !== want.status
                    || got.live_pages !== want.live_pages) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                             want.granted_address, want.status, want.live_pages,
                             got.granted_address, got.status, got.live_pages);
            end
        endfunction
    endclass

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;

    int          send_idle_pct = 19;
    int          recv_idle_pct = 69;
    int unsigned cycle_count   = 0;

    region_ledger ledger = new();

    refcounted_region_allocator u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic in_item_t alloc_of(input logic [SIZE_W-1:0] size);
        in_item_t req;
        req.op            = OP_ALLOC;
        req.size_bytes    = size;
        req.block_address = ADDR_W'($urandom);
        return req;
    endfunction

    function automatic in_item_t free_of(input logic [ADDR_W-1:0] addr);
        in_item_t req;
        req.op            = OP_FREE;
        req.size_bytes    = SIZE_W'($urandom);
        req.block_address = addr;
        return req;
    endfunction

    function automatic in_item_t random_request();
        int roll;
        int pick;

        roll = $urandom_range(0, 99);
        if (roll >= 40 && roll < 85 && ledger.held_blocks.size() != 0) begin
            random_request = free_of(ledger.held_blocks[
                $urandom_range(0, ledger.held_blocks.size() - 1)]);
            if ($urandom_range(0, 3) == 0)
                random_request.block_address[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
        end else if (roll >= 85) begin
            pick = $urandom_range(0, 2);
            if (pick == 0)
                random_request = free_of('0);
            else if (pick == 1)
                random_request = free_of(ADDR_W'($urandom));
            else
                random_request = free_of(ADDR_W'(($urandom_range(1, SLOTS) << PAGE_SHIFT)
                                                  | $urandom_range(0, PAGE_BYTES - 1)));
        end else begin
            pick = $urandom_range(0, 19);
            if (pick < 10)
                random_request = alloc_of(SIZE_W'($urandom_range(0, 64)));
            else if (pick < 14)
                random_request = alloc_of(SIZE_W'($urandom_range(65, 4096)));
            else if (pick < 17)
                random_request = alloc_of(SIZE_W'($urandom_range(4097, 262144)));
            else if (pick < 19)
                random_request = alloc_of(SIZE_W'($urandom_range(262145, PAGE_BYTES)));
            else
                random_request = alloc_of(
                    SIZE_W'($urandom_range(PAGE_BYTES + 1, (1 << SIZE_W) - 1)));
        end
    endfunction

    task automatic send_request(input in_item_t req);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        ledger.note_request(req);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (ledger.expected_results.size() != 0) @(posedge aclk);
    endtask

    // result side: check each transfer, then pick the next ready
    initial begin
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) ledger.check_result(m_data);
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("refcounted_region_allocator test failed");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(free_of('0));
        send_request(free_of(ADDR_W'(PAGE_BYTES + 16)));   // live page, no references
        send_request(free_of(ADDR_W'(5)));                 // below first page
        send_request(free_of('1));                         // past last slot
        send_request(free_of(ADDR_W'(3 * PAGE_BYTES)));    // slot not live
        send_request(alloc_of(SIZE_W'(0)));
        send_request(alloc_of('1));
        send_request(free_of(ADDR_W'(PAGE_BYTES)));        // last page emptied, stays live
        send_request(alloc_of(SIZE_W'(1)));
        // fill every slot, then one more to run out
        repeat (SLOTS) send_request(alloc_of(SIZE_W'(PAGE_BYTES)));
        send_request(free_of(ADDR_W'(6 * PAGE_BYTES)));    // release from mid-stack
        send_request(alloc_of(SIZE_W'(PAGE_BYTES)));
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 69;
                recv_idle_pct = 19;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < RANDOM_ITEMS / 3; n++) send_request(random_request());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (ledger.mismatches == 0 && ledger.expected_results.size() == 0)
            $display("refcounted_region_allocator test passed");
        else
            $display("refcounted_region_allocator test failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/rra_pkg.sv
hw/rtl/rra_ctrl.sv
hw/rtl/rra_datapath.sv
hw/rtl/refcounted_region_allocator.sv
verif/tb_refcounted_region_allocator.sv
